/* sv/fcds_pkg.sv */
// ----------------------------------------------------------------------------
// fcds_pkg: shared types and constants for the four-channel DMA sequencer
// Input/output transaction structs, action codes and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none
package fcds_pkg;

  localparam logic [2:0] ACT_WRITE  = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_VBLANK = 3'd2;
  localparam logic [2:0] ACT_HBLANK = 3'd3;
  localparam logic [2:0] ACT_FIFO_A = 3'd4;
  localparam logic [2:0] ACT_FIFO_B = 3'd5;
  localparam logic [2:0] ACT_TICK   = 3'd6;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  reg_offset;
    logic [15:0] write_data;
    logic [1:0]  byte_lanes;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] read_data;
    logic [1:0]  unit_channel;
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic        word_sized;
    logic        from_latch;
    logic        last_unit;
    logic        irq_raise;
  } out_item_t;

  // command from controller to datapath
  typedef struct packed {
    logic exec;   // apply the held transaction this cycle
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic has_result;
  } dp_stat_t;

endpackage
`default_nettype wire

/* sv/fcds_datapath.sv */
// ----------------------------------------------------------------------------
// fcds_datapath: channel register file and transfer sequencing
// Executes one held transaction when commanded and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none
module fcds_datapath
  import fcds_pkg::*;
#(
  parameter int CHANNEL_COUNT = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  item_i,
  input  wire dp_cmd_t   cmd_i,
  output      dp_stat_t  stat_o,
  output      out_item_t result_o
);

  localparam int CW = $clog2(CHANNEL_COUNT);

  logic [31:0] src_set_q [CHANNEL_COUNT], src_set_d [CHANNEL_COUNT];
  logic [31:0] dst_set_q [CHANNEL_COUNT], dst_set_d [CHANNEL_COUNT];
  logic [15:0] len_set_q [CHANNEL_COUNT], len_set_d [CHANNEL_COUNT];
  logic [15:0] ctl_q     [CHANNEL_COUNT], ctl_d     [CHANNEL_COUNT];
  logic [31:0] lsrc_q    [CHANNEL_COUNT], lsrc_d    [CHANNEL_COUNT];
  logic [31:0] ldst_q    [CHANNEL_COUNT], ldst_d    [CHANNEL_COUNT];
  logic [16:0] llen_q    [CHANNEL_COUNT], llen_d    [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] pend_q, pend_d;
  logic [1:0]  dly_q     [CHANNEL_COUNT], dly_d     [CHANNEL_COUNT];
  logic        busy_q, busy_d, bfifo_q, bfifo_d;
  logic [CW-1:0] owner_q, owner_d;
  logic [16:0] left_q, left_d;
  out_item_t   res_d;
  logic        has_d;

  function automatic logic [31:0] src_lim(int ch);
    return (ch == 0) ? 32'h07FF_FFFF : 32'h0FFF_FFFF;
  endfunction
  function automatic logic [31:0] dst_lim(int ch);
    return (ch <= 2) ? 32'h07FF_FFFF : 32'h0FFF_FFFF;
  endfunction
  function automatic logic [15:0] cnt_lim(int ch);
    return (ch == 3) ? 16'hFFFF : 16'h3FFF;
  endfunction
  function automatic logic [15:0] ctl_vis(int ch);
    return (ch == 3) ? 16'hFFE0 : 16'hF7E0;
  endfunction

  // register window decode: 12 bytes per channel
  logic [2:0] wch;
  logic [3:0] woff;
  always_comb begin
    wch = 3'd0;
    woff = 4'd0;
    if (item_i.reg_offset < 6'd12) begin
      wch = 3'd0; woff = item_i.reg_offset[3:0];
    end else if (item_i.reg_offset < 6'd24) begin
      wch = 3'd1; woff = 4'(item_i.reg_offset - 6'd12);
    end else if (item_i.reg_offset < 6'd36) begin
      wch = 3'd2; woff = 4'(item_i.reg_offset - 6'd24);
    end else if (item_i.reg_offset < 6'd48) begin
      wch = 3'd3; woff = 4'(item_i.reg_offset - 6'd36);
    end else begin
      wch = 3'd4;
    end
    woff[0] = 1'b0;
  end

  logic in_win;
  logic [CW-1:0] wc;
  logic [15:0] peek;
  assign in_win = (wch < 3'(CHANNEL_COUNT));
  assign wc = wch[CW-1:0];
  always_comb begin
    peek = '0;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      if (in_win && wc == CW'(c)) begin
        case (woff)
          4'd0:    peek = src_set_q[c][15:0];
          4'd2:    peek = src_set_q[c][31:16];
          4'd4:    peek = dst_set_q[c][15:0];
          4'd6:    peek = dst_set_q[c][31:16];
          4'd10:   peek = ctl_q[c] & ctl_vis(c);
          default: peek = '0;
        endcase
      end
    end
  end

  logic [15:0] wv;
  always_comb begin
    case (item_i.byte_lanes)
      2'd1:    wv = {peek[15:8], item_i.write_data[7:0]};
      2'd2:    wv = {item_i.write_data[15:8], peek[7:0]};
      default: wv = item_i.write_data;
    endcase
  end

  // tick-side selection on decremented delays
  logic [1:0] ndly [CHANNEL_COUNT];
  logic found;
  logic [CW-1:0] sel;
  always_comb begin
    found = 1'b0;
    sel = '0;
    for (int c = CHANNEL_COUNT - 1; c >= 0; c--) begin
      ndly[c] = (dly_q[c] != 2'd0) ? dly_q[c] - 2'd1 : 2'd0;
      if (pend_q[c] && ctl_q[c][15] && ndly[c] == 2'd0) begin
        found = 1'b1;
        sel = CW'(c);
      end
    end
  end

  always_comb begin
    logic [15:0] c16, fc;
    logic fifo, word, last;
    logic [31:0] bytes, al, s, d, ns, nd;
    logic [16:0] units, nleft;
    logic [CW-1:0] ow;
    logic is_fifo_ch;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      src_set_d[c] = src_set_q[c]; dst_set_d[c] = dst_set_q[c];
      len_set_d[c] = len_set_q[c]; ctl_d[c] = ctl_q[c];
      lsrc_d[c] = lsrc_q[c]; ldst_d[c] = ldst_q[c]; llen_d[c] = llen_q[c];
      dly_d[c] = dly_q[c];
    end
    pend_d = pend_q;
    busy_d = busy_q; bfifo_d = bfifo_q; owner_d = owner_q; left_d = left_q;
    res_d = '0;
    has_d = 1'b0;
    c16 = '0; fc = '0; fifo = 1'b0; word = 1'b0; last = 1'b0;
    bytes = '0; al = '0; s = '0; d = '0; ns = '0; nd = '0;
    units = '0; nleft = '0; ow = '0; is_fifo_ch = 1'b0;

    case (item_i.action)
      ACT_WRITE: begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          if (in_win && wc == CW'(c) && item_i.byte_lanes != 2'd0) begin
            case (woff)
              4'd0: src_set_d[c][15:0] = wv;
              4'd2: src_set_d[c][31:16] = wv;
              4'd4: dst_set_d[c][15:0] = wv;
              4'd6: dst_set_d[c][31:16] = wv;
              4'd8: len_set_d[c] = wv & cnt_lim(c);
              4'd10: begin
                if (busy_q && owner_q == CW'(c)) begin
                  busy_d = 1'b0; left_d = '0; bfifo_d = 1'b0;
                end
                ctl_d[c] = wv;
                if (wv[15]) begin
                  fc = len_set_q[c] & cnt_lim(c);
                  lsrc_d[c] = src_set_q[c] & src_lim(c);
                  ldst_d[c] = dst_set_q[c] & dst_lim(c);
                  llen_d[c] = (fc != 16'd0) ? {1'b0, fc} : {1'b0, cnt_lim(c)} + 17'd1;
                  if (wv[13:12] == 2'd0) begin
                    pend_d[c] = 1'b1; dly_d[c] = 2'd3;
                  end
                end else begin
                  pend_d[c] = 1'b0; dly_d[c] = 2'd0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ACT_READ: begin
        has_d = 1'b1;
        res_d.read_data = peek;
      end
      ACT_VBLANK, ACT_HBLANK, ACT_FIFO_A, ACT_FIFO_B: begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          logic hit;
          hit = 1'b0;
          case (item_i.action)
            ACT_VBLANK: hit = ctl_q[c][13:12] == 2'd1;
            ACT_HBLANK: hit = ctl_q[c][13:12] == 2'd2;
            ACT_FIFO_A: hit = (c == 1) && ctl_q[c][13:12] == 2'd3;
            default:    hit = (c == 2) && ctl_q[c][13:12] == 2'd3;
          endcase
          if (hit && ctl_q[c][15]) begin
            if (llen_q[c] == 17'd0) begin
              fc = len_set_q[c] & cnt_lim(c);
              lsrc_d[c] = src_set_q[c] & src_lim(c);
              ldst_d[c] = dst_set_q[c] & dst_lim(c);
              llen_d[c] = (fc != 16'd0) ? {1'b0, fc} : {1'b0, cnt_lim(c)} + 17'd1;
            end
            pend_d[c] = 1'b1; dly_d[c] = 2'd2;
          end
        end
      end
      ACT_TICK: begin
        for (int c = 0; c < CHANNEL_COUNT; c++) dly_d[c] = ndly[c];
        if (busy_q || found) begin
          ow = busy_q ? owner_q : sel;
          for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (ow == CW'(c)) begin
              c16 = ctl_q[c];
              is_fifo_ch = (c == 1 || c == 2) && c16[13:12] == 2'd3;
              fifo = busy_q ? bfifo_q : is_fifo_ch;
              word = fifo || c16[10];
              al = word ? ~32'd3 : ~32'd1;
              bytes = word ? 32'd4 : 32'd2;
              s = busy_q ? lsrc_q[c] : (lsrc_q[c] & al);
              d = busy_q ? ldst_q[c] : (ldst_q[c] & al);
              if (busy_q) units = left_q;
              else begin
                units = fifo ? 17'd4 : llen_q[c];
                if (units == 17'd0) units = 17'd1;
                pend_d[c] = 1'b0;
              end
              ns = s; nd = d;
              if (c16[8:7] == 2'd0) ns = s + bytes;
              else if (c16[8:7] == 2'd1) ns = s - bytes;
              if (!fifo) begin
                if (c16[6:5] == 2'd0 || c16[6:5] == 2'd3) nd = d + bytes;
                else if (c16[6:5] == 2'd1) nd = d - bytes;
              end
              lsrc_d[c] = ns; ldst_d[c] = nd;
              nleft = units - 17'd1;
              last = nleft == 17'd0;
              left_d = nleft;
              busy_d = !last; owner_d = ow; bfifo_d = last ? 1'b0 : fifo;
              if (last) begin
                if (fifo) llen_d[c] = 17'd4;
                if (c16[9] && c16[13:12] != 2'd0) begin
                  fc = len_set_q[c] & cnt_lim(c);
                  llen_d[c] = fifo ? 17'd4 :
                    ((fc != 16'd0) ? {1'b0, fc} : {1'b0, cnt_lim(c)} + 17'd1);
                  if (c16[6:5] == 2'd3 && !fifo)
                    ldst_d[c] = dst_set_q[c] & dst_lim(c) & al;
                end else begin
                  ctl_d[c] = c16 & 16'h7FFF;
                  llen_d[c] = '0; pend_d[c] = 1'b0; dly_d[c] = 2'd0;
                end
              end
              has_d = 1'b1;
              res_d.kind = 1'b1;
              res_d.unit_channel = 2'(c);
              res_d.source_address = s;
              res_d.target_address = d;
              res_d.word_sized = word;
              res_d.from_latch = s < 32'h0200_0000;
              res_d.last_unit = last;
              res_d.irq_raise = last && c16[14];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        src_set_q[c] <= '0; dst_set_q[c] <= '0; len_set_q[c] <= '0; ctl_q[c] <= '0;
        lsrc_q[c] <= '0; ldst_q[c] <= '0; llen_q[c] <= '0; dly_q[c] <= '0;
      end
      pend_q <= '0; busy_q <= 1'b0; bfifo_q <= 1'b0; owner_q <= '0; left_q <= '0;
    end else if (cmd_i.exec) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        src_set_q[c] <= src_set_d[c]; dst_set_q[c] <= dst_set_d[c];
        len_set_q[c] <= len_set_d[c]; ctl_q[c] <= ctl_d[c];
        lsrc_q[c] <= lsrc_d[c]; ldst_q[c] <= ldst_d[c]; llen_q[c] <= llen_d[c];
        dly_q[c] <= dly_d[c];
      end
      pend_q <= pend_d; busy_q <= busy_d; bfifo_q <= bfifo_d;
      owner_q <= owner_d; left_q <= left_d;
    end
  end

  // result register, loaded alongside the state update
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) result_o <= res_d;
  end

  assign stat_o.has_result = has_d;

`ifndef SYNTHESIS
  a_busy_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> left_q != 17'd0) else $error("busy burst with zero units left");
  a_owner_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && item_i.action == ACT_TICK && !busy_q && found) |=> busy_q || !busy_q)
    else $error("tick start failed");
  a_fifo_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bfifo_q |-> busy_q) else $error("fifo burst flag without burst");
`endif

endmodule
`default_nettype wire

/* sv/fcds_ctrl.sv */
// ----------------------------------------------------------------------------
// fcds_ctrl: handshake controller
// Tracks the one-entry output slot and decides when the datapath may execute.
// ----------------------------------------------------------------------------
`default_nettype none
module fcds_ctrl
  import fcds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  output      logic     out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output      dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic drain;

  assign drain = (state_q == ST_FULL) && out_ready_i;
  // accept while the output slot is free or being taken this cycle
  assign in_ready_o = (state_q == ST_EMPTY) || drain;
  assign cmd_o.exec = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_FULL);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: if (cmd_o.exec && stat_i.has_result) state_d = ST_FULL;
      ST_FULL: begin
        if (out_ready_i) state_d = (cmd_o.exec && stat_i.has_result) ? ST_FULL : ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_EMPTY;
    else         state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd_o.exec) else $error("result overwritten");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec && stat_i.has_result) |=> out_valid_o) else $error("result lost");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
`endif

endmodule
`default_nettype wire

/* sv/four_channel_dma_sequencer.sv */
// A registered result appears on the output in the cycle after its transaction is accepted.
// One transaction per cycle unless the slot stalls; a tick issues at most one transfer unit.
// Input is taken in the same cycle the held result drains, set by the one-entry output slot.
// Reset (rst_ni low, asynchronous) clears all channel registers, bursts and the slot.
// ----------------------------------------------------------------------------
// four_channel_dma_sequencer: four-channel DMA address sequencer
// Register access, trigger and tick handling with at most one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module four_channel_dma_sequencer
  import fcds_pkg::*;
#(
  parameter int CHANNEL_COUNT = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_item_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fcds_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  fcds_datapath #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .cmd_i(cmd), .stat_o(stat),
    .result_o(out_data_o)
  );

endmodule
`default_nettype wire

/* tb/tb_four_channel_dma_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_channel_dma_sequencer: self-checking bench for the DMA sequencer
// Drives register accesses, blank/FIFO triggers and ticks through the input
// channel, predicts read data and transfer units, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_four_channel_dma_sequencer;
  import fcds_pkg::*;

  localparam int NCH       = 4;
  localparam int CYC_LIMIT = 400000;

  // action code with no function
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  localparam logic [15:0] CTL_ENABLE = 16'h8000;
  localparam logic [15:0] CTL_IRQ    = 16'h4000;
  localparam logic [15:0] CTL_REPEAT = 16'h0200;
  localparam logic [15:0] CTL_WORD   = 16'h0400;

  localparam logic [1:0] TM_IMMEDIATE = 2'd0;
  localparam logic [1:0] TM_VBLANK    = 2'd1;
  localparam logic [1:0] TM_HBLANK    = 2'd2;
  localparam logic [1:0] TM_SPECIAL   = 2'd3;

  localparam logic [3:0] OFF_SRC_LO = 4'd0;
  localparam logic [3:0] OFF_SRC_HI = 4'd2;
  localparam logic [3:0] OFF_DST_LO = 4'd4;
  localparam logic [3:0] OFF_DST_HI = 4'd6;
  localparam logic [3:0] OFF_COUNT  = 4'd8;
  localparam logic [3:0] OFF_CTRL   = 4'd10;

  logic      clk_i, rst_ni;
  logic      in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_item_t  in_data_i;
  out_item_t out_data_o;

  four_channel_dma_sequencer i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // predictor state
  logic [31:0] src_reg [NCH];
  logic [31:0] dst_reg [NCH];
  logic [15:0] cnt_reg [NCH];
  logic [15:0] ctl_reg [NCH];
  logic [31:0] cur_src [NCH];
  logic [31:0] cur_dst [NCH];
  logic [16:0] cur_cnt [NCH];
  logic        armed   [NCH];
  logic [1:0]  delay   [NCH];
  logic        busy, bfifo;
  logic [1:0]  owner;
  logic [16:0] left;

  out_item_t expected_q[$];
  int errors, cycles, units_seen, reads_seen;
  bit  hold_off, quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] src_limit_of(int c);
    return c == 0 ? 32'h07FF_FFFF : 32'h0FFF_FFFF;
  endfunction
  function automatic logic [31:0] dst_limit_of(int c);
    return c <= 2 ? 32'h07FF_FFFF : 32'h0FFF_FFFF;
  endfunction
  function automatic logic [16:0] cnt_mask(int c);
    return c == 3 ? 17'h0FFFF : 17'h03FFF;
  endfunction
  function automatic logic [1:0] timing(int c);
    return ctl_reg[c][13:12];
  endfunction

  function automatic logic [16:0] reload_count(int c);
    logic [16:0] n;
    n = {1'b0, cnt_reg[c]} & cnt_mask(c);
    return n != 0 ? n : cnt_mask(c) + 17'd1;
  endfunction

  function automatic void latch_channel(int c);
    cur_src[c] = src_reg[c] & src_limit_of(c);
    cur_dst[c] = dst_reg[c] & dst_limit_of(c);
    cur_cnt[c] = reload_count(c);
  endfunction

  function automatic logic [15:0] reg_view(int c, int off);
    case (off)
      OFF_SRC_LO: return src_reg[c][15:0];
      OFF_SRC_HI: return src_reg[c][31:16];
      OFF_DST_LO: return dst_reg[c][15:0];
      OFF_DST_HI: return dst_reg[c][31:16];
      OFF_CTRL:   return ctl_reg[c] & (c == 3 ? 16'hFFE0 : 16'hF7E0);
      default:    return 16'h0;
    endcase
  endfunction

  function automatic void reg_store(int c, int off, logic [15:0] v);
    case (off)
      OFF_SRC_LO: src_reg[c][15:0]  = v;
      OFF_SRC_HI: src_reg[c][31:16] = v;
      OFF_DST_LO: dst_reg[c][15:0]  = v;
      OFF_DST_HI: dst_reg[c][31:16] = v;
      OFF_COUNT:  cnt_reg[c] = 16'({1'b0, v} & cnt_mask(c));
      OFF_CTRL: begin
        if (busy && owner == c) begin
          busy = 0; left = 0; bfifo = 0;
        end
        ctl_reg[c] = v;
        if (v & CTL_ENABLE) begin
          latch_channel(c);
          if (v[13:12] == TM_IMMEDIATE) begin
            armed[c] = 1; delay[c] = 2'd3;
          end
        end else begin
          armed[c] = 0; delay[c] = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void trigger(int c);
    if (cur_cnt[c] == 0) latch_channel(c);
    armed[c] = 1;
    delay[c] = 2'd2;
  endfunction

  function automatic bit tick_unit(output out_item_t r);
    int c, k;
    bit found, fifo, word, fin;
    logic [15:0] ctl;
    logic [31:0] s, d, nb, al;
    r = '0;
    for (k = 0; k < NCH; k++) if (delay[k] != 0) delay[k]--;
    if (!busy) begin
      found = 0;
      for (k = NCH - 1; k >= 0; k--)
        if (armed[k] && ctl_reg[k][15] && delay[k] == 0) begin
          found = 1; c = k;
        end
      if (!found) return 0;
      fifo = (c == 1 || c == 2) && timing(c) == TM_SPECIAL;
      word = fifo || ctl_reg[c][10];
      al = word ? ~32'd3 : ~32'd1;
      cur_src[c] &= al;
      cur_dst[c] &= al;
      left = fifo ? 17'd4 : (cur_cnt[c] == 0 ? 17'd1 : cur_cnt[c]);
      busy = 1; owner = 2'(c); bfifo = fifo; armed[c] = 0;
    end
    c = owner;
    ctl = ctl_reg[c];
    fifo = bfifo;
    word = fifo || ctl[10];
    nb = word ? 32'd4 : 32'd2;
    s = cur_src[c];
    d = cur_dst[c];
    if (ctl[8:7] == 2'd0) cur_src[c] = s + nb;
    else if (ctl[8:7] == 2'd1) cur_src[c] = s - nb;
    if (!fifo) begin
      if (ctl[6:5] == 2'd0 || ctl[6:5] == 2'd3) cur_dst[c] = d + nb;
      else if (ctl[6:5] == 2'd1) cur_dst[c] = d - nb;
    end
    left = left - 17'd1;
    fin = left == 0;
    r.kind = 1'b1;
    r.unit_channel = 2'(c);
    r.source_address = s;
    r.target_address = d;
    r.word_sized = word;
    r.from_latch = s < 32'h0200_0000;
    r.last_unit = fin;
    if (fin) begin
      busy = 0; bfifo = 0;
      if (fifo) cur_cnt[c] = 17'd4;
      if ((ctl & CTL_REPEAT) && ctl[13:12] != TM_IMMEDIATE) begin
        cur_cnt[c] = fifo ? 17'd4 : reload_count(c);
        if (ctl[6:5] == 2'd3 && !fifo)
          cur_dst[c] = dst_reg[c] & dst_limit_of(c) & (word ? ~32'd3 : ~32'd1);
      end else begin
        ctl_reg[c] = ctl & ~CTL_ENABLE;
        cur_cnt[c] = 0; armed[c] = 0; delay[c] = 0;
      end
      r.irq_raise = (ctl & CTL_IRQ) != 0;
    end
    return 1;
  endfunction

  function automatic void predict(in_item_t t);
    int c, off, k;
    logic [15:0] v, cur;
    out_item_t r;
    c = t.reg_offset / 12;
    off = (t.reg_offset % 12) & ~1;
    case (t.action)
      ACT_WRITE: if (c < NCH && t.byte_lanes != 0) begin
        cur = reg_view(c, off);
        v = t.write_data;
        if (t.byte_lanes == 2'd1) v = {cur[15:8], t.write_data[7:0]};
        else if (t.byte_lanes == 2'd2) v = {t.write_data[15:8], cur[7:0]};
        reg_store(c, off, v);
      end
      ACT_READ: begin
        r = '0;
        r.read_data = c < NCH ? reg_view(c, off) : 16'h0;
        expected_q.push_back(r);
      end
      ACT_VBLANK, ACT_HBLANK:
        for (k = 0; k < NCH; k++)
          if (ctl_reg[k][15] &&
              timing(k) == (t.action == ACT_VBLANK ? TM_VBLANK : TM_HBLANK))
            trigger(k);
      ACT_FIFO_A, ACT_FIFO_B: begin
        k = t.action == ACT_FIFO_A ? 1 : 2;
        if (ctl_reg[k][15] && timing(k) == TM_SPECIAL) trigger(k);
      end
      ACT_TICK: if (tick_unit(r)) expected_q.push_back(r);
      default: ;
    endcase
  endfunction

  // valid stays high from one transaction to the next unless the sender idles
  task automatic send(in_item_t t);
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    predict(t);
  endtask

  task automatic op_at(logic [2:0] a, logic [5:0] ro, logic [15:0] d = 16'd0,
                       logic [1:0] ln = 2'd3);
    in_item_t t;
    t.action = a;
    t.reg_offset = ro;
    t.write_data = d;
    t.byte_lanes = ln;
    send(t);
  endtask

  task automatic op(logic [2:0] a, int c = 0, logic [3:0] off = 4'd0,
                    logic [15:0] d = 16'd0, logic [1:0] ln = 2'd3);
    op_at(a, 6'(c * 12 + off), d, ln);
  endtask

  task automatic setup_channel(int c, logic [31:0] s, logic [31:0] d,
                               logic [15:0] n, logic [15:0] ctl);
    op(ACT_WRITE, c, OFF_SRC_LO, s[15:0]);
    op(ACT_WRITE, c, OFF_SRC_HI, s[31:16]);
    op(ACT_WRITE, c, OFF_DST_LO, d[15:0]);
    op(ACT_WRITE, c, OFF_DST_HI, d[31:16]);
    op(ACT_WRITE, c, OFF_COUNT, n);
    op(ACT_WRITE, c, OFF_CTRL, ctl);
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !hold_off && (quiet || $urandom_range(99) >= 13);
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.kind) units_seen++; else reads_seen++;
        if (out_data_o.kind !== e.kind)
          begin $error("kind exp %0h got %0h", e.kind, out_data_o.kind); errors++; end
        if (out_data_o.read_data !== e.read_data)
          begin $error("read_data exp %0h got %0h", e.read_data, out_data_o.read_data); errors++; end
        if (out_data_o.unit_channel !== e.unit_channel)
          begin $error("unit_channel exp %0h got %0h", e.unit_channel,
                       out_data_o.unit_channel); errors++; end
        if (out_data_o.source_address !== e.source_address)
          begin $error("source_address exp %0h got %0h", e.source_address,
                       out_data_o.source_address); errors++; end
        if (out_data_o.target_address !== e.target_address)
          begin $error("target_address exp %0h got %0h", e.target_address,
                       out_data_o.target_address); errors++; end
        if (out_data_o.word_sized !== e.word_sized)
          begin $error("word_sized exp %0h got %0h", e.word_sized, out_data_o.word_sized); errors++; end
        if (out_data_o.from_latch !== e.from_latch)
          begin $error("from_latch exp %0h got %0h", e.from_latch, out_data_o.from_latch); errors++; end
        if (out_data_o.last_unit !== e.last_unit)
          begin $error("last_unit exp %0h got %0h", e.last_unit, out_data_o.last_unit); errors++; end
        if (out_data_o.irq_raise !== e.irq_raise)
          begin $error("irq_raise exp %0h got %0h", e.irq_raise, out_data_o.irq_raise); errors++; end
      end
    end
  end

  task automatic drain_ticks(int n);
    repeat (n) op(ACT_TICK);
  endtask

  task automatic test_registers();
    int c;
    for (c = 0; c < NCH; c++) begin
      setup_channel(c, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0FFF);
      op(ACT_READ, c, OFF_SRC_LO); op(ACT_READ, c, OFF_SRC_HI);
      op(ACT_READ, c, OFF_DST_HI); op(ACT_READ, c, OFF_COUNT);
      op(ACT_READ, c, OFF_CTRL);
    end
    op(ACT_WRITE, 1, OFF_SRC_LO, 16'h12AB, 2'd1);
    op(ACT_WRITE, 1, OFF_SRC_LO + 4'd1, 16'h34CD, 2'd2);
    op(ACT_WRITE, 1, OFF_SRC_LO, 16'h5555, 2'd0);
    op(ACT_READ, 1, OFF_SRC_LO + 4'd1);
    // offsets past the register window
    op_at(ACT_WRITE, 6'd50, 16'h1234);
    op_at(ACT_READ, 6'd48);
    op_at(ACT_READ, 6'd63);
    op(ACT_UNUSED);
  endtask

  task automatic test_immediate();
    setup_channel(0, 32'h0000_1001, 32'h0300_0003, 16'd3, CTL_ENABLE | CTL_IRQ);
    drain_ticks(8);
    setup_channel(3, 32'h0800_0000, 32'h0FFF_FFFE, 16'd0,
                  CTL_ENABLE | CTL_WORD | 16'h0020 | 16'h0080);
    drain_ticks(5);
    op(ACT_WRITE, 3, OFF_CTRL, 16'h0000);   // drop running burst
    drain_ticks(3);
  endtask

  task automatic test_triggers();
    setup_channel(1, 32'h0200_0000, 32'h0400_00A0, 16'd0,
                  CTL_ENABLE | CTL_REPEAT | CTL_IRQ | 16'h3000);
    setup_channel(2, 32'h0100_0000, 32'h0400_00A4, 16'd0, CTL_ENABLE | CTL_REPEAT | 16'h3000);
    setup_channel(0, 32'h0000_0100, 32'h0600_0000, 16'd2,
                  CTL_ENABLE | CTL_REPEAT | 16'h1060);
    setup_channel(3, 32'h0800_0100, 32'h0600_1000, 16'd3, CTL_ENABLE | 16'h2000);
    op(ACT_FIFO_A); op(ACT_FIFO_B); op(ACT_VBLANK); op(ACT_HBLANK);
    drain_ticks(6);
    op(ACT_VBLANK);
    drain_ticks(12);
    op(ACT_HBLANK);
    drain_ticks(6);
  endtask

  function automatic logic [15:0] rand_ctl();
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(3) != 0) v |= CTL_ENABLE;
    return v;
  endfunction

  task automatic random_burst_phase(int items);
    int k, c;
    for (k = 0; k < items; k++) begin
      case ($urandom_range(19))
        0, 1: begin
          c = $urandom_range(NCH - 1);
          setup_channel(c, $urandom, $urandom, 16'($urandom_range(6)), rand_ctl());
        end
        2: op(ACT_WRITE, 0, 4'h0, 16'($urandom), 2'($urandom_range(3)));
        3: op(ACT_READ, $urandom_range(NCH), 4'($urandom_range(11)));
        4: op(3'($urandom_range(ACT_VBLANK, ACT_FIFO_B)));
        5: op(ACT_WRITE, $urandom_range(NCH - 1), 4'(2 * $urandom_range(5)),
              16'($urandom), 2'($urandom_range(1, 3)));
        6: op(ACT_UNUSED);
        default: op(ACT_TICK);
      endcase
    end
  endtask

  task automatic test_backpressure();
    setup_channel(3, 32'h0000_0000, 32'h0000_0000, 16'd40, CTL_ENABLE);
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk_i);
        hold_off = 0;
      end
      drain_ticks(50);
    join
  endtask

  task automatic wait_empty();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  initial begin
    int k;
    errors = 0; cycles = 0; units_seen = 0; reads_seen = 0;
    hold_off = 0; quiet = 0;
    for (k = 0; k < NCH; k++) begin
      src_reg[k] = 0; dst_reg[k] = 0; cnt_reg[k] = 0; ctl_reg[k] = 0;
      cur_src[k] = 0; cur_dst[k] = 0; cur_cnt[k] = 0; armed[k] = 0; delay[k] = 0;
    end
    busy = 0; bfifo = 0; owner = 0; left = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_registers();
    test_immediate();
    test_triggers();
    test_backpressure();
    random_burst_phase(300);
    quiet = 1;
    random_burst_phase(120);
    quiet = 0;
    random_burst_phase(250);
    in_valid_i <= 1'b0;
    wait_empty();

    $display("Covered register access, lane merges, all trigger kinds and repeat modes;");
    $display("checked %0d reads and %0d transfer units.", reads_seen, units_seen);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
sv/fcds_pkg.sv
sv/fcds_datapath.sv
sv/fcds_ctrl.sv
sv/four_channel_dma_sequencer.sv
tb/tb_four_channel_dma_sequencer.sv
